[rtl/rmtfq_pkg.sv]
// ----------------------------------------------------------------------------
// rmtfq_pkg
// Shared widths, operation and status codes and the control bundle that the
// top level hands to every list cell.
// ----------------------------------------------------------------------------
`default_nettype none

package rmtfq_pkg;

  // Field widths
  localparam int ID_W   = 7;
  localparam int FUNC_W = 2;
  localparam int ST_W   = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ROTATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PICK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

  // Per-cycle command to the cell row
  typedef struct packed {
    logic load;    // reload the list from the new length
    logic rotate;  // move the front identifier to the back
    logic pick;    // move the found identifier to the front
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/rmtfq_cell.sv]
// ----------------------------------------------------------------------------
// rmtfq_cell
// One list position. Holds one identifier, compares it with the picked
// identifier and takes its value from a neighbour on rotate and pick.
// ----------------------------------------------------------------------------
`default_nettype none

module rmtfq_cell #(
  parameter int INDEX     = 0,
  parameter int LEN_W     = 7,
  parameter int RESET_LEN = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rmtfq_pkg::cell_ctl_t       ctl,
  input  wire logic [LEN_W-1:0]           len,
  input  wire logic [LEN_W-1:0]           load_len,
  input  wire logic [rmtfq_pkg::ID_W-1:0] pick_id,
  input  wire logic [rmtfq_pkg::ID_W-1:0] head_id,
  input  wire logic [rmtfq_pkg::ID_W-1:0] left_id,
  input  wire logic [rmtfq_pkg::ID_W-1:0] right_id,
  input  wire logic                       shift,
  output logic      [rmtfq_pkg::ID_W-1:0] id,
  output logic                            match
);
  import rmtfq_pkg::*;

  // Position counted from one, and the identifier loaded here
  localparam logic [LEN_W-1:0] POS      = LEN_W'(INDEX + 1);
  localparam logic [ID_W-1:0]  LOAD_ID  = ID_W'(INDEX + 1);
  localparam logic [ID_W-1:0]  RESET_ID = (INDEX < RESET_LEN) ? LOAD_ID : '0;

  logic [ID_W-1:0] id_r;
  logic [ID_W-1:0] id_nxt;

  // Compare only while this position lies inside the list
  assign match = (POS <= len) && (id_r == pick_id);
  assign id    = id_r;

  // Select the next identifier
  always_comb begin
    id_nxt = id_r;
    if (ctl.load) begin
      id_nxt = (POS <= load_len) ? LOAD_ID : '0;
    end else if (ctl.rotate) begin
      if (POS < len) begin
        id_nxt = right_id;
      end else if (POS == len) begin
        id_nxt = head_id;
      end
    end else if (ctl.pick && shift) begin
      id_nxt = left_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= RESET_ID;
    end else begin
      id_r <= id_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/rmtfq_prefix.sv]
// ----------------------------------------------------------------------------
// rmtfq_prefix
// Parallel prefix OR over the cell match flags: bit i is set when any cell
// at or before position i matches. Log-depth tree of two-input ORs.
// ----------------------------------------------------------------------------
`default_nettype none

module rmtfq_prefix #(
  parameter int N = 64
) (
  input  wire logic [N-1:0] match,
  output logic      [N-1:0] seen
);
  localparam int LV = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [0:LV];

  assign lvl[0] = match;

  // Combine each bit with the one a power of two below it
  for (genvar k = 0; k < LV; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign seen = lvl[LV];

endmodule

`default_nettype wire

[rtl/rotating_move_to_front_queue.sv]
// ----------------------------------------------------------------------------
// rotating_move_to_front_queue
// Ordered list of identifiers held in a row of cells; rotate, pick to front
// and query, one result with front identifier and status per item.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one item per cycle unless the result side stalls; the whole cell
//   row compares and shifts at once, with a log-depth prefix OR locating the first match.
// Reset loads 1 .. min(64, MAX_ENTRIES) at once; a count write reloads the
//   list in the same cycle. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rotating_move_to_front_queue #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration: entry_count[6:0]
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [6:0] cfg_data,
  // Input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [6:0] pick_id, [7] zero fill
  input  wire logic [1:0] in_tuser,   // [1:0] func
  // Result stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // [6:0] front_id, [7] zero fill
  output logic      [1:0] out_tuser   // [1:0] status
);
  import rmtfq_pkg::*;

  localparam int LEN_W     = $clog2(MAX_ENTRIES + 1);
  localparam int RESET_LEN = (MAX_ENTRIES < 64) ? MAX_ENTRIES : 64;

  logic [LEN_W-1:0] used_len_r;
  logic [LEN_W-1:0] used_len_nxt;
  logic [LEN_W-1:0] load_len;

  logic             out_valid_r;
  logic [ID_W-1:0]  out_id_r;
  logic [ST_W-1:0]  out_st_r;
  logic [ID_W-1:0]  front_nxt;
  logic [ST_W-1:0]  st_nxt;

  logic [ID_W-1:0]  cell_id [0:MAX_ENTRIES-1];
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES-1:0] seen;

  logic             accept;
  logic             empty;
  logic             found;
  logic             is_rotate;
  logic             is_pick;
  logic [ID_W-1:0]  pick_id;
  cell_ctl_t        ctl;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign pick_id   = in_tdata[ID_W-1:0];
  assign empty     = (used_len_r == '0);
  assign found     = seen[MAX_ENTRIES-1];

  // Decode the operation; unused code behaves as query
  always_comb begin
    is_rotate = 1'b0;
    is_pick   = 1'b0;
    unique case (in_tuser)
      FUNC_ROTATE: is_rotate = 1'b1;
      FUNC_PICK:   is_pick   = 1'b1;
      default:     ;
    endcase
  end

  // Saturate the written count to the capacity
  assign load_len = (32'(cfg_data) > 32'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES)
                                                       : LEN_W'(cfg_data);

  // Command to the cell row
  always_comb begin
    ctl.load   = cfg_valid;
    ctl.rotate = accept && !empty && is_rotate;
    ctl.pick   = accept && !empty && is_pick && found;
  end

  // Cell row
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [ID_W-1:0] left_id;
    logic [ID_W-1:0] right_id;
    logic            shift;

    if (i == 0) begin : g_first
      assign left_id = pick_id;
      assign shift   = 1'b1;
    end else begin : g_mid
      assign left_id = cell_id[i-1];
      assign shift   = !seen[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign right_id = '0;
    end else begin : g_inner
      assign right_id = cell_id[i+1];
    end

    rmtfq_cell #(
      .INDEX     (i),
      .LEN_W     (LEN_W),
      .RESET_LEN (RESET_LEN)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .len      (used_len_r),
      .load_len (load_len),
      .pick_id  (pick_id),
      .head_id  (cell_id[0]),
      .left_id  (left_id),
      .right_id (right_id),
      .shift    (shift),
      .id       (cell_id[i]),
      .match    (match[i])
    );
  end

  // Locate the first match
  rmtfq_prefix #(
    .N (MAX_ENTRIES)
  ) u_prefix (
    .match (match),
    .seen  (seen)
  );

  // Front identifier and status after the step
  always_comb begin
    front_nxt = cell_id[0];
    st_nxt    = ST_OK;
    if (empty) begin
      front_nxt = '0;
      st_nxt    = ST_EMPTY;
    end else if (is_rotate) begin
      front_nxt = (used_len_r == LEN_W'(1)) ? cell_id[0] : cell_id[1];
    end else if (is_pick) begin
      if (found) begin
        front_nxt = pick_id;
      end else begin
        st_nxt = ST_MISSING;
      end
    end
  end

  // Length register: reload on count write
  assign used_len_nxt = cfg_valid ? load_len : used_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_len_r <= LEN_W'(RESET_LEN);
    end else begin
      used_len_r <= used_len_nxt;
    end
  end

  // Result register: hold until transfer, refill on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_id_r <= front_nxt;
      out_st_r <= st_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_id_r};
  assign out_tuser  = out_st_r;

  // Empty list always reports the empty status
  a_empty_status : assert property (@(posedge clk) disable iff (!rst_n)
    accept && empty && !cfg_valid |=> out_tuser == ST_EMPTY && out_tdata == '0)
    else $error("empty list gave wrong result");

  // A found pick brings the identifier to the front
  a_pick_front : assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pick && !cfg_valid |=> cell_id[0] == $past(pick_id))
    else $error("picked identifier not at front");

  // A missed pick leaves the front alone
  a_miss_hold : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !empty && is_pick && !found && !cfg_valid |=> $stable(cell_id[0]))
    else $error("missed pick changed the front");

  // Length stays within capacity
  a_len_cap : assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_len_r) <= 32'(MAX_ENTRIES))
    else $error("length above capacity");

  // Reported front matches the cell row after the step
  a_front_match : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !empty && !cfg_valid |=> out_tdata[ID_W-1:0] == cell_id[0])
    else $error("reported front differs from cell row");

endmodule

`default_nettype wire

[verif/tb_rotating_move_to_front_queue.sv]
// ----------------------------------------------------------------------------
// tb_rotating_move_to_front_queue
// Self-checking bench for the move-to-front identifier list. A behavioural
// copy of the list follows every accepted item and predicts the front
// identifier and status. Each result transfer is checked against the oldest
// prediction. Directed tests cover the reset list, the empty list, a single
// entry and an oversized count. Random traffic then runs under several count
// settings, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_rotating_move_to_front_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import rmtfq_pkg::*;

  localparam int                MAX_ENTRIES = 64;
  localparam int                CYCLE_LIMIT = 300000;
  localparam int                DRAIN_WAIT  = 8;
  localparam logic [FUNC_W-1:0] FUNC_SPARE  = 2'd3;  // unused code, acts as query

  typedef struct packed {
    logic [ID_W-1:0] front_id;
    logic [ST_W-1:0] status;
  } front_result_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [6:0]        cfg_data   = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;   // [6:0] pick_id, [7] zero fill
  logic [1:0]        in_tuser   = '0;   // [1:0] func
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic [7:0]        out_tdata;         // [6:0] front_id, [7] zero fill
  logic [1:0]        out_tuser;         // [1:0] status

  // Behavioural copy of the list
  logic [ID_W-1:0]   list_ids [MAX_ENTRIES];
  int                list_len;

  front_result_t     pending_fronts [$];
  int                n_errors    = 0;
  int                cycle_count = 0;
  int                burst_left  = 1;
  bit                sender_gaps = 1'b1;
  int                stall_mode  = 0;
  int                stall_left  = 0;

  rotating_move_to_front_queue #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side back-pressure: switch at random between free running, random
  // and periodic stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 300);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ((cycle_count % 7) >= 2);
    endcase
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    front_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_fronts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got front_id %0d status %0d",
                 $time, out_tdata[6:0], out_tuser);
        n_errors++;
      end else begin
        exp_res = pending_fronts.pop_front();
        if (out_tdata[6:0] !== exp_res.front_id) begin
          $display("%0t: front_id mismatch, expected %0d, got %0d",
                   $time, exp_res.front_id, out_tdata[6:0]);
          n_errors++;
        end
        if (out_tuser !== exp_res.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, exp_res.status, out_tuser);
          n_errors++;
        end
      end
    end
  end

  // Reload the list with 1 .. count, saturated to capacity
  function automatic void reload_list(input logic [6:0] count);
    int n;
    n = (count > MAX_ENTRIES) ? MAX_ENTRIES : int'(count);
    for (int i = 0; i < MAX_ENTRIES; i++)
      list_ids[i] = (i < n) ? ID_W'(i + 1) : '0;
    list_len = n;
  endfunction

  // Apply one operation to the list and return the front and status
  function automatic front_result_t move_to_front_step(input logic [FUNC_W-1:0] func,
                                                       input logic [ID_W-1:0]   id);
    front_result_t   res;
    logic [ID_W-1:0] head;
    int              pos;
    res.status = ST_OK;
    if (list_len == 0) begin
      res.front_id = '0;
      res.status   = ST_EMPTY;
      return res;
    end
    case (func)
      FUNC_ROTATE: begin
        head = list_ids[0];
        for (int i = 0; i + 1 < list_len; i++)
          list_ids[i] = list_ids[i + 1];
        list_ids[list_len - 1] = head;
      end
      FUNC_PICK: begin
        pos = -1;
        for (int i = 0; i < list_len; i++)
          if (pos < 0 && list_ids[i] == id) pos = i;
        if (pos < 0) begin
          res.status = ST_MISSING;
        end else begin
          for (int i = pos; i > 0; i--)
            list_ids[i] = list_ids[i - 1];
          list_ids[0] = id;
        end
      end
      default: ;
    endcase
    res.front_id = list_ids[0];
    return res;
  endfunction

  // Drive one item, wait for its transfer, record the prediction, then pace
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {1'b0, id};
    do @(posedge clk); while (!in_tready);
    pending_fronts.push_back(move_to_front_step(func, id));
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drain outstanding results, then write the count register
  task automatic write_count(input logic [6:0] count);
    in_tvalid <= 1'b0;
    while (pending_fronts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reload_list(count);
  endtask

  task automatic test_reset_list();
    send_item(FUNC_QUERY,  7'd0);
    send_item(FUNC_ROTATE, 7'd0);
    send_item(FUNC_PICK,   7'd64);   // second to last slot to the front
    send_item(FUNC_PICK,   7'd1);    // now at the back after the rotate
    send_item(FUNC_PICK,   7'd127);  // not present, all bits set
    send_item(FUNC_PICK,   7'd0);    // zero is never present
    send_item(FUNC_PICK,   7'd65);   // above the length
    send_item(FUNC_SPARE,  7'd5);
    send_item(FUNC_ROTATE, 7'd0);
    send_item(FUNC_ROTATE, 7'd0);
  endtask

  task automatic test_empty_list();
    write_count(7'd0);
    send_item(FUNC_ROTATE, 7'd0);
    send_item(FUNC_PICK,   7'd1);
    send_item(FUNC_QUERY,  7'd0);
    send_item(FUNC_SPARE,  7'd127);
  endtask

  task automatic test_single_entry();
    write_count(7'd1);
    send_item(FUNC_ROTATE, 7'd0);
    send_item(FUNC_PICK,   7'd1);
    send_item(FUNC_PICK,   7'd2);
    send_item(FUNC_QUERY,  7'd0);
  endtask

  task automatic test_count_saturation();
    write_count(7'd127);
    send_item(FUNC_QUERY,  7'd0);
    send_item(FUNC_PICK,   7'd64);
    send_item(FUNC_ROTATE, 7'd0);
    send_item(FUNC_PICK,   7'd65);
  endtask

  // Random operations under a range of counts; picks mostly hit the list
  task automatic test_random_traffic();
    logic [6:0]        counts [10];
    int                n_items;
    int                r;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
    counts = '{7'd2, 7'd127, 7'($urandom_range(1, 8)), 7'd0, 7'd64,
               7'($urandom_range(3, 16)), 7'd1, 7'($urandom_range(1, 64)),
               7'd63, 7'd5};
    foreach (counts[p]) begin
      write_count(counts[p]);
      sender_gaps = (p % 3 != 2);
      n_items = (counts[p] == 0) ? 20 : 120;
      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 19);
        if (r < 9)       func = FUNC_PICK;
        else if (r < 14) func = FUNC_ROTATE;
        else if (r < 18) func = FUNC_QUERY;
        else             func = FUNC_SPARE;
        if (list_len > 0 && $urandom_range(0, 9) < 8)
          id = ID_W'($urandom_range(1, list_len));
        else
          id = ID_W'($urandom_range(0, 127));
        send_item(func, id);
      end
    end
  endtask

  initial begin
    reload_list(7'd64);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_list();
    test_empty_list();
    test_single_entry();
    test_count_saturation();
    test_random_traffic();

    // Drain and let any stray result show up
    in_tvalid <= 1'b0;
    while (pending_fronts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
